@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL. In synthesis the bodies are empty.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, checking suspended while the active-low reset is low.
`define QTU_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("qtu assertion failed");

// Clocked property that also holds during reset.
`define QTU_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("qtu assertion failed");

`else

`define QTU_ASSERT(label, clk, rstn, prop)
`define QTU_ASSERT_NR(label, clk, prop)

`endif

`endif

@@ rtl/core/qtu_pkg.sv @@
package qtu_pkg;

    // Field widths of the stream payloads.
    localparam int STATE_W  = 10;
    localparam int ACT_W    = 2;
    localparam int REWARD_W = 16;
    localparam int RATE_W   = 16;
    localparam int QVAL_W   = 32;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    typedef logic [STATE_W-1:0]         state_idx_t;
    typedef logic [ACT_W-1:0]           act_t;
    typedef logic signed [REWARD_W-1:0] reward_t;
    typedef logic [RATE_W-1:0]          rate_t;
    typedef logic signed [QVAL_W-1:0]   qval_t;

    // Command codes carried in s_tuser.
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Configuration register indexes.
    localparam logic REG_LEARNING_RATE = 1'b0;
    localparam logic REG_DISCOUNT      = 1'b1;

    // Register reset values (alpha about 0.1, gamma about 0.9).
    localparam rate_t LEARNING_RATE_RESET = 16'd6554;
    localparam rate_t DISCOUNT_RESET      = 16'd58982;

    // Stage enables for the update datapath.
    typedef struct packed {
        logic mul1_en;
        logic diff_en;
        logic mul2_en;
    } math_ctl_t;

endpackage

@@ rtl/core/q_table_update_and_greedy.sv @@
// Tabular Q-learning store with greedy action lookup.
// Input stream (s_*): one beat per command. s_tuser selects update or query.
// An update applies Q += alpha*(reward + gamma*maxNext - Q) to one entry,
// saturating to 32 bits; a query returns the first action with the largest
// written value of a state. Every input beat gives exactly one output beat.
// Output stream (m_*): one beat per command, in order, held in an output
// register so the next command is taken while a result waits.
// Steps: a query passes ST_GREEDY and ST_FIN before its result beat is loaded;
// an update passes ST_GREEDY, ST_MUL1, ST_DIFF, ST_MUL2 and ST_FIN. The block
// handles one command at a time; the next beat can be accepted in the cycle after
// the previous result is loaded. The update cost is set by two reads of the
// single value/mask memory port (next state, then current state) and the two
// dependent multiplies, each followed by a register.
// Configuration: cfg_wen writes learning_rate (index 0) or discount (index 1);
// write only while the block is idle.
// Reset: aresetn clears control state and loads the rate reset values, then the
// written mask is cleared state by state, during which s_tready stays low.
// Stall: if m_tready is low the finished result holds in the output register;
// a following command runs up to its write-back and waits there.
`include "assert_macros.svh"

module q_table_update_and_greedy #(
    parameter int NUM_STATES  = 1024,
    parameter int NUM_ACTIONS = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // state_index[9:0], action[11:10], reward[27:12], next_state_index[37:28]
    input  logic [qtu_pkg::S_DATA_W-1:0]    s_tdata,
    // command[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // best_action[1:0], new_value[33:2], state_known[34], saturated[35]
    output logic [qtu_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                            cfg_wen,
    input  logic                            cfg_index,
    input  qtu_pkg::rate_t                  cfg_wdata
);

    localparam int SW = $clog2(NUM_STATES);
    localparam int AW = $clog2(NUM_ACTIONS);
    localparam int RW = NUM_ACTIONS * qtu_pkg::QVAL_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GREEDY,
        ST_MUL1,
        ST_DIFF,
        ST_MUL2,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;

    // Input fields.
    qtu_pkg::state_idx_t in_s, in_ns;
    qtu_pkg::act_t       in_a;
    qtu_pkg::reward_t    in_r;
    assign in_s  = s_tdata[9:0];
    assign in_a  = s_tdata[11:10];
    assign in_r  = s_tdata[27:12];
    assign in_ns = s_tdata[37:28];

    // Registers of the command in flight.
    logic                cmd_reg;
    qtu_pkg::state_idx_t s_reg;
    qtu_pkg::act_t       a_reg;
    qtu_pkg::reward_t    r_reg;
    logic                s_ok_reg, ns_ok_reg, a_ok_reg;
    logic [RW-1:0]          row_reg;
    logic [NUM_ACTIONS-1:0] mask_reg;
    qtu_pkg::qval_t         cur_reg;
    qtu_pkg::rate_t      lr_reg, disc_reg;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [qtu_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic accept, out_load, busy;
    logic [AW-1:0] a_idx;

    // Memory and unit connections.
    logic                   rd_en;
    logic [SW-1:0]          rd_addr;
    logic [RW-1:0]          rd_row;
    logic [NUM_ACTIONS-1:0] rd_mask;
    logic                   wr_en;
    logic [RW-1:0]          wr_row;
    logic [NUM_ACTIONS-1:0] wr_mask;
    logic [AW-1:0]          g_act;
    qtu_pkg::qval_t         g_val;
    logic                   g_found;
    qtu_pkg::math_ctl_t     math_ctl;
    qtu_pkg::qval_t         upd_val;
    logic                   upd_sat;
    logic                   known_c;

    assign s_tready = (state_reg == ST_IDLE) && !busy;
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);
    assign a_idx    = AW'(a_reg);

    // First read: the queried state, or the next state of an update.
    // Second read (updates only): the current state's row.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = SW'(s_reg);
        if (accept) begin
            rd_en   = 1'b1;
            rd_addr = (s_tuser == qtu_pkg::CMD_QUERY) ? SW'(in_s) : SW'(in_ns);
        end else if (state_reg == ST_GREEDY && cmd_reg == qtu_pkg::CMD_UPDATE) begin
            rd_en = 1'b1;
        end
    end

    qtu_store #(
        .NUM_STATES  (NUM_STATES),
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_row  (rd_row),
        .rd_mask (rd_mask),
        .wr_en   (wr_en),
        .wr_addr (SW'(s_reg)),
        .wr_row  (wr_row),
        .wr_mask (wr_mask),
        .busy    (busy)
    );

    qtu_greedy #(
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_greedy (
        .aclk     (aclk),
        .en       (state_reg == ST_GREEDY),
        .in_range ((cmd_reg == qtu_pkg::CMD_QUERY) ? s_ok_reg : ns_ok_reg),
        .row      (rd_row),
        .mask     (rd_mask),
        .best_act (g_act),
        .best_val (g_val),
        .found    (g_found)
    );

    assign math_ctl.mul1_en = (state_reg == ST_MUL1);
    assign math_ctl.diff_en = (state_reg == ST_DIFF);
    assign math_ctl.mul2_en = (state_reg == ST_MUL2);

    qtu_math u_math (
        .aclk     (aclk),
        .ctl      (math_ctl),
        .alpha    (lr_reg),
        .gamma    (disc_reg),
        .reward   (r_reg),
        .max_next (g_val),
        .cur      (cur_reg),
        .result   (upd_val),
        .sat      (upd_sat)
    );

    // Write-back row and mask of the updated state.
    always_comb begin
        wr_row  = row_reg;
        wr_mask = mask_reg;
        if (a_ok_reg) begin
            wr_row[a_idx*qtu_pkg::QVAL_W +: qtu_pkg::QVAL_W] = upd_val;
            wr_mask[a_idx] = 1'b1;
        end
    end
    assign wr_en   = out_load && (cmd_reg == qtu_pkg::CMD_UPDATE) && a_ok_reg;
    assign known_c = s_ok_reg && (wr_mask != '0);

    // Next state and result beat.
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_GREEDY;
                end
            end
            ST_GREEDY: begin
                state_next = (cmd_reg == qtu_pkg::CMD_QUERY) ? ST_FIN : ST_MUL1;
            end
            ST_MUL1: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_FIN;
            ST_FIN: begin
                if (out_load) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    if (cmd_reg == qtu_pkg::CMD_QUERY) begin
                        m_tdata_next = {4'b0, 1'b0, g_found, g_val, qtu_pkg::act_t'(g_act)};
                    end else begin
                        m_tdata_next = {4'b0, upd_sat, known_c, upd_val, a_reg};
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State, configuration, command registers and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            lr_reg       <= qtu_pkg::LEARNING_RATE_RESET;
            disc_reg     <= qtu_pkg::DISCOUNT_RESET;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            if (cfg_wen) begin
                case (cfg_index)
                    qtu_pkg::REG_LEARNING_RATE: lr_reg   <= cfg_wdata;
                    qtu_pkg::REG_DISCOUNT:      disc_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                cmd_reg   <= s_tuser;
                s_reg     <= in_s;
                a_reg     <= in_a;
                r_reg     <= in_r;
                s_ok_reg  <= 32'(in_s) < NUM_STATES;
                ns_ok_reg <= 32'(in_ns) < NUM_STATES;
                a_ok_reg  <= (32'(in_s) < NUM_STATES) && (32'(in_a) < NUM_ACTIONS);
            end
            // Current state's row arrives here; unwritten entries read as zero.
            if (state_reg == ST_MUL1) begin
                row_reg  <= rd_row;
                mask_reg <= s_ok_reg ? rd_mask : '0;
                if (a_ok_reg && rd_mask[a_idx]) begin
                    cur_reg <= $signed(rd_row[a_idx*qtu_pkg::QVAL_W +: qtu_pkg::QVAL_W]);
                end else begin
                    cur_reg <= '0;
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // No command is taken while the mask memory is being cleared.
    `QTU_ASSERT_NR(a_no_accept_in_clear, aclk, busy |-> !s_tready)
    // The memory is written only when the result beat is loaded.
    `QTU_ASSERT(a_write_at_load, aclk, aresetn, wr_en |-> out_load)
    // A result never overwrites one that has not been taken.
    `QTU_ASSERT(a_no_overwrite, aclk, aresetn, out_load |-> (!m_tvalid || m_tready))
    // An accepted command always leaves the idle state.
    `QTU_ASSERT(a_accept_leaves_idle, aclk, aresetn, accept |=> state_reg != ST_IDLE)

endmodule

@@ rtl/core/qtu_store.sv @@
module qtu_store #(
    parameter int NUM_STATES  = 1024,
    parameter int NUM_ACTIONS = 4,
    localparam int SW = $clog2(NUM_STATES),
    localparam int RW = NUM_ACTIONS * qtu_pkg::QVAL_W
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   rd_en,
    input  logic [SW-1:0]          rd_addr,
    output logic [RW-1:0]          rd_row,
    output logic [NUM_ACTIONS-1:0] rd_mask,
    input  logic                   wr_en,
    input  logic [SW-1:0]          wr_addr,
    input  logic [RW-1:0]          wr_row,
    input  logic [NUM_ACTIONS-1:0] wr_mask,
    output logic                   busy
);

    // One row holds all action values of a state; the mask memory marks written entries.
    logic [RW-1:0]          q_mem [NUM_STATES];
    logic [NUM_ACTIONS-1:0] mask_mem [NUM_STATES];

    logic          clr_busy_reg;
    logic [SW-1:0] clr_addr_reg;

    // Clearing pass over the mask memory after reset, one state per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == SW'(NUM_STATES - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign busy = clr_busy_reg;

    // Value memory: registered read, row-wide write.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            q_mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            rd_row <= q_mem[rd_addr];
        end
    end

    // Mask memory: the clearing pass owns the write port while it runs.
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mask_mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mask_mem[wr_addr] <= wr_mask;
        end
        if (rd_en) begin
            rd_mask <= mask_mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/qtu_greedy.sv @@
module qtu_greedy #(
    parameter int NUM_ACTIONS = 4,
    localparam int AW = $clog2(NUM_ACTIONS),
    localparam int RW = NUM_ACTIONS * qtu_pkg::QVAL_W
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic                   in_range,
    input  logic [RW-1:0]          row,
    input  logic [NUM_ACTIONS-1:0] mask,
    output logic [AW-1:0]          best_act,
    output qtu_pkg::qval_t         best_val,
    output logic                   found
);

    logic [AW-1:0]  act_c;
    qtu_pkg::qval_t val_c;
    logic           found_c;

    // First written action with the strictly largest value wins.
    always_comb begin
        act_c   = '0;
        val_c   = '0;
        found_c = 1'b0;
        for (int a = 0; a < NUM_ACTIONS; a++) begin
            if (in_range && mask[a]) begin
                if (!found_c ||
                    $signed(row[a*qtu_pkg::QVAL_W +: qtu_pkg::QVAL_W]) > val_c) begin
                    val_c   = $signed(row[a*qtu_pkg::QVAL_W +: qtu_pkg::QVAL_W]);
                    act_c   = AW'(a);
                    found_c = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            best_act <= act_c;
            best_val <= val_c;
            found    <= found_c;
        end
    end

endmodule

@@ rtl/core/qtu_math.sv @@
module qtu_math (
    input  logic               aclk,
    input  qtu_pkg::math_ctl_t ctl,
    input  qtu_pkg::rate_t     alpha,
    input  qtu_pkg::rate_t     gamma,
    input  qtu_pkg::reward_t   reward,
    input  qtu_pkg::qval_t     max_next,
    input  qtu_pkg::qval_t     cur,
    output qtu_pkg::qval_t     result,
    output logic               sat
);

    logic signed [48:0] prod1_c, prod1_reg;
    logic signed [33:0] diff_c, diff_reg;
    logic signed [50:0] prod2_c, prod2_reg;
    logic signed [35:0] res_c;

    // Stage 1: gamma * maxNext, exact.
    assign prod1_c = $signed({1'b0, gamma}) * max_next;

    // Stage 2: reward widened to Q16.16 plus the floored discount term, minus Q.
    assign diff_c = $signed({{10{reward[15]}}, reward, 8'b0})
                  + 34'(prod1_reg >>> 16) - 34'(cur);

    // Stage 3: alpha * difference, exact.
    assign prod2_c = $signed({1'b0, alpha}) * diff_reg;

    always_ff @(posedge aclk) begin
        if (ctl.mul1_en) begin
            prod1_reg <= prod1_c;
        end
        if (ctl.diff_en) begin
            diff_reg <= diff_c;
        end
        if (ctl.mul2_en) begin
            prod2_reg <= prod2_c;
        end
    end

    // Final add with the floored step, clamped to 32 bits.
    assign res_c = 36'(cur) + 36'(prod2_reg >>> 16);

    always_comb begin
        sat    = 1'b0;
        result = res_c[31:0];
        if (res_c > 36'sd2147483647) begin
            sat    = 1'b1;
            result = 32'sh7FFF_FFFF;
        end else if (res_c < -36'sd2147483648) begin
            sat    = 1'b1;
            result = 32'sh8000_0000;
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import qtu_pkg::*;

    localparam int NUM_ST      = 1024;
    localparam int NUM_ACT     = 4;
    localparam int STALL_LIMIT = 6000;
    localparam int RAND_PHASES = 6;
    localparam int RAND_ITEMS  = 150;
    localparam int SWEEP_ITEMS = 320;
    localparam int CROSS_ITEMS = 24;

    localparam act_t   ACT_UP   = 2'd0;
    localparam rate_t  RATE_MIN = 16'h0000;
    localparam rate_t  RATE_MAX = 16'hFFFF;
    localparam longint QV_MAX   = 64'sd2147483647;
    localparam longint QV_MIN   = -64'sd2147483648;

    typedef struct {
        logic       cmd;
        state_idx_t s;
        act_t       a;
        reward_t    r;
        state_idx_t ns;
    } q_cmd_t;

    typedef struct {
        act_t  act;
        qval_t val;
        logic  known;
        logic  sat;
    } q_result_t;

    typedef struct {
        q_cmd_t    c;
        logic      fixed_exp;
        q_result_t res;
    } dir_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_wen;
    logic                cfg_index;
    rate_t               cfg_wdata;

    // Shadow of the Q table, its written mask and the two rate registers.
    qval_t              q_est [NUM_ST][NUM_ACT];
    logic [NUM_ACT-1:0] wmask [NUM_ST];
    rate_t              alpha_r;
    rate_t              gamma_r;

    q_result_t  awaited_results [$];
    state_idx_t hot_states [16];
    int         src_gap_max    = 4;
    int         sink_stall_max = 4;
    int         n_errors       = 0;
    int         n_updates      = 0;
    int         n_queries      = 0;
    int         n_clamped      = 0;
    int         quiet_cycles   = 0;

    q_table_update_and_greedy #(
        .NUM_STATES  (NUM_ST),
        .NUM_ACTIONS (NUM_ACT)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Greedy scan over the written actions of a state; the first strict maximum wins.
    function automatic logic best_written(input state_idx_t s, output act_t act,
                                          output qval_t val);
        logic found;
        found = 1'b0;
        act   = ACT_UP;
        val   = '0;
        for (int a = 0; a < NUM_ACT; a++) begin
            if (wmask[s][a] && (!found || q_est[s][a] > val)) begin
                val   = q_est[s][a];
                act   = act_t'(a);
                found = 1'b1;
            end
        end
        return found;
    endfunction

    // Applies one command to the shadow table and returns the beat it must produce.
    function automatic q_result_t q_learn_step(input q_cmd_t c);
        q_result_t res;
        act_t      na;
        qval_t     nv;
        longint    cur;
        longint    diff;
        longint    upd;
        if (c.cmd == CMD_QUERY) begin
            res.known = best_written(c.s, res.act, res.val);
            res.sat   = 1'b0;
            return res;
        end
        cur = wmask[c.s][c.a] ? longint'(q_est[c.s][c.a]) : 64'sd0;
        // An empty next state leaves nv at zero.
        void'(best_written(c.ns, na, nv));
        // Both products are floored, which an arithmetic shift of a signed value gives.
        diff = longint'(c.r) * 256 + ((longint'(gamma_r) * longint'(nv)) >>> 16) - cur;
        upd  = cur + ((longint'(alpha_r) * diff) >>> 16);
        res.sat = (upd > QV_MAX) || (upd < QV_MIN);
        if (upd > QV_MAX) begin
            upd = QV_MAX;
        end else if (upd < QV_MIN) begin
            upd = QV_MIN;
        end
        q_est[c.s][c.a] = qval_t'(upd);
        wmask[c.s][c.a] = 1'b1;
        res.act   = c.a;
        res.val   = qval_t'(upd);
        res.known = 1'b1;
        return res;
    endfunction

    function automatic dir_row_t drow(input logic cmd, input int s, input int a, input int r,
                                      input int ns, input logic fixed_exp, input int e_act,
                                      input int e_val, input logic e_known);
        dir_row_t row;
        row.c.cmd     = cmd;
        row.c.s       = state_idx_t'(s);
        row.c.a       = act_t'(a);
        row.c.r       = reward_t'(r);
        row.c.ns      = state_idx_t'(ns);
        row.fixed_exp = fixed_exp;
        row.res.act   = act_t'(e_act);
        row.res.val   = qval_t'(e_val);
        row.res.known = e_known;
        row.res.sat   = 1'b0;
        return row;
    endfunction

    // Most states come from a small hot set so that values build up and get reused.
    function automatic state_idx_t pick_state();
        if ($urandom_range(0, 3) != 0) begin
            return hot_states[$urandom_range(0, 15)];
        end
        return state_idx_t'($urandom);
    endfunction

    function automatic q_cmd_t rand_cmd();
        q_cmd_t c;
        c.cmd = ($urandom_range(0, 9) < 3) ? CMD_QUERY : CMD_UPDATE;
        c.s   = pick_state();
        c.ns  = pick_state();
        c.a   = act_t'($urandom);
        case ($urandom_range(0, 7))
            0: begin
                c.r = 16'sh7FFF;
            end
            1: begin
                c.r = 16'sh8000;
            end
            default: begin
                c.r = reward_t'($urandom);
            end
        endcase
        return c;
    endfunction

    // Drives one command beat after a random gap and records what it must return.
    task automatic send_cmd(input q_cmd_t c, input logic fixed_exp, input q_result_t lit);
        int        gap;
        q_result_t want;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.cmd;
        s_tdata  <= {2'b00, c.ns, c.r, c.a, c.s};
        do @(posedge aclk); while (!s_tready);
        want = q_learn_step(c);
        awaited_results.push_back(fixed_exp ? lit : want);
        if (c.cmd == CMD_QUERY) begin
            n_queries++;
        end else begin
            n_updates++;
        end
    endtask

    // Called in the step of the last acceptance; returns once every result is back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_rate(input logic idx, input rate_t val);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        if (idx == REG_LEARNING_RATE) begin
            alpha_r = val;
        end else begin
            gamma_r = val;
        end
    endtask

    // Result side: after each beat, optionally hold tready low for a while once data shows.
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = $urandom_range(0, sink_stall_max);
            if (stall == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                do @(posedge aclk); while (!m_tvalid);
                repeat (stall - 1) @(posedge aclk);
                m_tready <= 1'b1;
            end
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // Compare every result beat with the oldest outstanding prediction.
    always @(posedge aclk) begin : result_check
        q_result_t want;
        act_t      got_act;
        qval_t     got_val;
        logic      got_known;
        logic      got_sat;
        if (aresetn && m_tvalid && m_tready) begin
            got_act   = m_tdata[1:0];
            got_val   = m_tdata[33:2];
            got_known = m_tdata[34];
            got_sat   = m_tdata[35];
            if (got_sat === 1'b1) begin
                n_clamped++;
            end
            if (awaited_results.size() == 0) begin
                $error("Result beat arrived with no command outstanding.");
                n_errors++;
            end else begin
                want = awaited_results.pop_front();
                if (got_act !== want.act) begin
                    $error("best_action: expected %0d, got %0d", want.act, got_act);
                    n_errors++;
                end
                if (got_val !== want.val) begin
                    $error("new_value: expected %0d, got %0d", want.val, got_val);
                    n_errors++;
                end
                if (got_known !== want.known) begin
                    $error("state_known: expected %0d, got %0d", want.known, got_known);
                    n_errors++;
                end
                if (got_sat !== want.sat) begin
                    $error("saturated: expected %0d, got %0d", want.sat, got_sat);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves a beat.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Timed out after %0d cycles without a beat.", STALL_LIMIT);
            $display("q_table_update_and_greedy regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        dir_row_t   rows [$];
        q_cmd_t     c;
        q_result_t  blank;
        state_idx_t sat_st [2];
        rate_t      lr;
        rate_t      dc;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = CMD_UPDATE;
        s_tdata   = '0;
        cfg_wen   = 1'b0;
        cfg_index = REG_LEARNING_RATE;
        cfg_wdata = '0;
        blank     = '{ACT_UP, '0, 1'b0, 1'b0};
        alpha_r   = LEARNING_RATE_RESET;
        gamma_r   = DISCOUNT_RESET;
        for (int i = 0; i < NUM_ST; i++) begin
            wmask[i] = '0;
            for (int j = 0; j < NUM_ACT; j++) begin
                q_est[i][j] = '0;
            end
        end
        hot_states[0] = '0;
        hot_states[1] = '1;
        for (int i = 2; i < 16; i++) begin
            hot_states[i] = state_idx_t'($urandom);
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Nothing is written after reset, so every query returns up with value 0.
        rows.push_back(drow(CMD_QUERY,  0,     0, 0,      0,     1'b1, 0, 0, 1'b0));
        rows.push_back(drow(CMD_QUERY,  1023,  3, 32767,  1023,  1'b1, 0, 0, 1'b0));
        // Zero reward toward an empty next state writes a value of 0.
        rows.push_back(drow(CMD_UPDATE, 0,     0, 0,      1023,  1'b1, 0, 0, 1'b1));
        rows.push_back(drow(CMD_QUERY,  0,     0, 0,      0,     1'b1, 0, 0, 1'b1));
        // Extreme rewards on the top state, then updates through its own row.
        rows.push_back(drow(CMD_UPDATE, 1023,  3, 32767,  0,     1'b0, 0, 0, 1'b0));
        rows.push_back(drow(CMD_UPDATE, 1023,  0, -32768, 1023,  1'b0, 0, 0, 1'b0));
        rows.push_back(drow(CMD_QUERY,  1023,  0, 0,      0,     1'b0, 0, 0, 1'b0));
        rows.push_back(drow(CMD_UPDATE, 1023,  1, 32767,  1023,  1'b0, 0, 0, 1'b0));
        rows.push_back(drow(CMD_UPDATE, 1023,  2, -32768, 1023,  1'b0, 0, 0, 1'b0));
        rows.push_back(drow(CMD_QUERY,  1023,  1, 0,      0,     1'b0, 0, 0, 1'b0));
        // Equal values: the lowest written action is the greedy one.
        rows.push_back(drow(CMD_UPDATE, 2,     3, 0,      5,     1'b1, 3, 0, 1'b1));
        rows.push_back(drow(CMD_UPDATE, 2,     1, 0,      5,     1'b1, 1, 0, 1'b1));
        rows.push_back(drow(CMD_QUERY,  2,     0, 0,      0,     1'b1, 1, 0, 1'b1));
        // A single negative value still beats the unwritten entries.
        rows.push_back(drow(CMD_UPDATE, 3,     2, -256,   3,     1'b0, 0, 0, 1'b0));
        rows.push_back(drow(CMD_QUERY,  3,     0, 0,      0,     1'b0, 0, 0, 1'b0));
        // Alternating bit patterns through every field.
        rows.push_back(drow(CMD_UPDATE, 'h2AA, 1, 'h5555, 'h155, 1'b0, 0, 0, 1'b0));
        rows.push_back(drow(CMD_UPDATE, 'h155, 2, 'hAAAA, 'h2AA, 1'b0, 0, 0, 1'b0));
        rows.push_back(drow(CMD_QUERY,  'h2AA, 2, 'hAAAA, 'h155, 1'b0, 0, 0, 1'b0));
        rows.push_back(drow(CMD_QUERY,  'h155, 1, 'h5555, 'h2AA, 1'b0, 0, 0, 1'b0));
        rows.push_back(drow(CMD_UPDATE, 4,     0, 32767,  1023,  1'b0, 0, 0, 1'b0));
        foreach (rows[i]) begin
            send_cmd(rows[i].c, rows[i].fixed_exp, rows[i].res);
        end
        wait_drained();

        // Full rates on self-loops push one value to each clamp, then feed one into the other.
        write_rate(REG_LEARNING_RATE, RATE_MAX);
        write_rate(REG_DISCOUNT, RATE_MAX);
        src_gap_max   = 0;
        sat_st[0]     = 10'h0F0;
        sat_st[1]     = 10'h30F;
        for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < SWEEP_ITEMS; i++) begin
                c.cmd = (i % 8 == 7) ? CMD_QUERY : CMD_UPDATE;
                c.s   = sat_st[k];
                c.ns  = sat_st[k];
                c.a   = ACT_UP;
                c.r   = (k == 0) ? 16'sh7FFF : 16'sh8000;
                send_cmd(c, 1'b0, blank);
            end
        end
        for (int i = 0; i < CROSS_ITEMS; i++) begin
            c    = rand_cmd();
            c.s  = sat_st[(i + 1) % 2];
            c.ns = sat_st[i % 2];
            if (i == 0) begin
                c.cmd = CMD_UPDATE;
                c.a   = ACT_UP;
                c.r   = 16'sh7FFF;
            end
            send_cmd(c, 1'b0, blank);
        end
        wait_drained();

        // Random traffic under the rate extremes, random rates and the reset rates.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin
                    lr = RATE_MIN;
                    dc = RATE_MIN;
                end
                1: begin
                    lr = RATE_MAX;
                    dc = RATE_MIN;
                end
                2: begin
                    lr = RATE_MIN;
                    dc = RATE_MAX;
                end
                RAND_PHASES - 1: begin
                    lr = LEARNING_RATE_RESET;
                    dc = DISCOUNT_RESET;
                end
                default: begin
                    lr = rate_t'($urandom);
                    dc = rate_t'($urandom);
                end
            endcase
            write_rate(REG_LEARNING_RATE, lr);
            write_rate(REG_DISCOUNT, dc);
            src_gap_max    = ($urandom_range(0, 2) == 0) ? 0 : 4;
            sink_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
            repeat (RAND_ITEMS) send_cmd(rand_cmd(), 1'b0, blank);
            wait_drained();
        end

        // Any stray beat after the last expected one is caught by the checker.
        repeat (16) @(posedge aclk);
        $display("Sent %0d updates and %0d queries under %0d rate settings with random gaps.",
                 n_updates, n_queries, RAND_PHASES + 2);
        $display("%0d results came back clamped; %0d mismatches found.", n_clamped, n_errors);
        if (n_errors == 0) begin
            $display("q_table_update_and_greedy regression: pass");
        end else begin
            $display("q_table_update_and_greedy regression: fail");
        end
        $finish;
    end

endmodule
